FILE: design/dms_pkg.sv
// shared types and constants for the dataset statistics block
// word layouts, accumulator status, engine status and sequencer states
// no dependencies
package dms_pkg;

	localparam int MAX_COUNT     = 4096;
	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 8;

	localparam int COUNT_BITS = $clog2(MAX_COUNT + 1);
	localparam int LOG_COUNT  = $clog2(MAX_COUNT);
	localparam int SUM_BITS   = SAMPLE_BITS + LOG_COUNT;
	localparam int SQ_BITS    = 2 * SAMPLE_BITS + LOG_COUNT - 1;
	localparam int PROD_BITS  = SAMPLE_BITS + SUM_BITS;
	localparam int WORK_BITS  = SQ_BITS;
	localparam int VAR_BITS   = 2 * SAMPLE_BITS;
	localparam int ROOT_BITS  = SAMPLE_BITS + FRACTION_BITS;
	localparam int REM_BITS   = ROOT_BITS + 3;
	localparam int STEP_BITS  = $clog2(WORK_BITS);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mean;
		logic [ROOT_BITS-1:0]          std_dev_q8;
		logic signed [SAMPLE_BITS-1:0] minimum;
		logic signed [SAMPLE_BITS-1:0] maximum;
		logic [COUNT_BITS-1:0]         sample_count;
		logic                          overflow;
	} out_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0]    sum;
		logic [SQ_BITS-1:0]            sq;
		logic [COUNT_BITS-1:0]         count;
		logic signed [SAMPLE_BITS-1:0] min_val;
		logic signed [SAMPLE_BITS-1:0] max_val;
		logic                          too_many;
	} acc_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic acc_clear;
	} eng_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV_MEAN,
		ST_MUL,
		ST_DEV,
		ST_DIV_VAR,
		ST_PREP,
		ST_ROOT
	} state_t;

endpackage

FILE: design/dms_accum.sv
// running sum, sum of squares, count, minimum and maximum of the current set
// depends on dms_pkg
module dms_accum (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic signed [dms_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic                                    clear,
	output dms_pkg::acc_t                           acc
);
	import dms_pkg::*;

	logic signed [SUM_BITS-1:0]    sum_q;
	logic [SQ_BITS-1:0]            sq_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic                          too_many_q;
	logic                          full;
	logic signed [2*SAMPLE_BITS-1:0] square;

	assign full   = count_q >= COUNT_BITS'(MAX_COUNT);
	assign square = sample * sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			sq_q       <= '0;
			count_q    <= '0;
			too_many_q <= 1'b0;
		end else if (clear) begin
			sum_q      <= '0;
			sq_q       <= '0;
			count_q    <= '0;
			too_many_q <= 1'b0;
		end else if (accept) begin
			if (full) begin
				too_many_q <= 1'b1;
			end else begin
				sum_q   <= sum_q + SUM_BITS'(sample);
				sq_q    <= sq_q + SQ_BITS'($unsigned(square));
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			if (count_q == '0 || sample < min_q) begin
				min_q <= sample;
			end
			if (count_q == '0 || sample > max_q) begin
				max_q <= sample;
			end
		end
	end

	assign acc.sum      = sum_q;
	assign acc.sq       = sq_q;
	assign acc.count    = count_q;
	assign acc.min_val  = min_q;
	assign acc.max_val  = max_q;
	assign acc.too_many = too_many_q;

endmodule

FILE: design/dms_unit.sv
// shared trial subtractor used by both divisions and the square root
// depends on dms_pkg
module dms_unit (
	input  logic [dms_pkg::REM_BITS-1:0] a,
	input  logic [dms_pkg::REM_BITS-1:0] b,
	output logic [dms_pkg::REM_BITS-1:0] diff,
	output logic                         borrow
);
	import dms_pkg::*;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

FILE: design/dms_engine.sv
// end-of-set sequencer: mean division, deviation sum, variance division, square root
// depends on dms_pkg and dms_unit
module dms_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               taken,
	input  dms_pkg::acc_t      acc,
	output dms_pkg::eng_stat_t stat,
	output dms_pkg::out_t      result
);
	import dms_pkg::*;

	state_t state_q, state_d;
	logic [STEP_BITS-1:0] step_q;
	logic                 div_last, root_last;

	logic [COUNT_BITS-1:0]         n_q;
	logic                          neg_q;
	logic [SUM_BITS-1:0]           abs_s_q;
	logic [SQ_BITS-1:0]            sq_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic                          ovf_q;
	logic [WORK_BITS-1:0]          work_q;
	logic [REM_BITS-1:0]           rem_q;
	logic [SAMPLE_BITS-1:0]        absm_q;
	logic [PROD_BITS-1:0]          prod_q;
	logic [VAR_BITS-1:0]           rad_q;
	logic [ROOT_BITS-1:0]          root_q;

	logic [COUNT_BITS:0]    div_shift;
	logic [REM_BITS-1:0]    root_shift;
	logic [REM_BITS-1:0]    op_a, op_b, diff;
	logic                   borrow;
	logic [SUM_BITS-1:0]    sum_adj;
	logic [PROD_BITS-1:0]   prod_c;
	logic                   done_q;

	assign div_last  = step_q == STEP_BITS'(WORK_BITS - 1);
	assign root_last = step_q == STEP_BITS'(ROOT_BITS - 1);

	assign div_shift  = {rem_q[COUNT_BITS-1:0], work_q[WORK_BITS-1]};
	assign root_shift = {rem_q[REM_BITS-3:0], rad_q[VAR_BITS-1 -: 2]};

	always_comb begin
		if (state_q == ST_ROOT) begin
			op_a = root_shift;
			op_b = REM_BITS'({root_q, 2'b01});
		end else begin
			op_a = REM_BITS'(div_shift);
			op_b = REM_BITS'(n_q);
		end
	end

	dms_unit u_unit (
		.a      (op_a),
		.b      (op_b),
		.diff   (diff),
		.borrow (borrow)
	);

	assign sum_adj = abs_s_q + SUM_BITS'(rem_q[COUNT_BITS-1:0]);
	assign prod_c  = PROD_BITS'(work_q[SAMPLE_BITS-1:0]) * PROD_BITS'(sum_adj);

	// done is a registered flag: the root has finished and the word is not yet taken
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_LOAD;
			end
			ST_LOAD:     state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: begin
				if (div_last) state_d = ST_MUL;
			end
			ST_MUL:      state_d = ST_DEV;
			ST_DEV:      state_d = ST_DIV_VAR;
			ST_DIV_VAR: begin
				if (div_last) state_d = ST_PREP;
			end
			ST_PREP:     state_d = ST_ROOT;
			ST_ROOT: begin
				if (done_q && taken) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		stat.busy      = state_q != ST_IDLE;
		stat.done      = done_q;
		stat.acc_clear = state_q == ST_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_DIV_MEAN, ST_DIV_VAR: begin
					step_q <= div_last ? '0 : step_q + 1'b1;
				end
				ST_ROOT: begin
					if (!done_q) begin
						step_q <= root_last ? '0 : step_q + 1'b1;
						done_q <= root_last;
					end else if (taken) begin
						done_q <= 1'b0;
					end
				end
				default: begin
					step_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				neg_q   <= acc.sum[SUM_BITS-1];
				abs_s_q <= acc.sum[SUM_BITS-1] ? SUM_BITS'(-acc.sum) : SUM_BITS'(acc.sum);
				work_q  <= acc.sum[SUM_BITS-1] ? WORK_BITS'($unsigned(SUM_BITS'(-acc.sum)))
				                               : WORK_BITS'($unsigned(acc.sum));
				n_q     <= acc.count;
				sq_q    <= acc.sq;
				min_q   <= acc.min_val;
				max_q   <= acc.max_val;
				ovf_q   <= acc.too_many;
				rem_q   <= '0;
			end
			ST_DIV_MEAN, ST_DIV_VAR: begin
				rem_q  <= borrow ? REM_BITS'(div_shift) : diff;
				work_q <= {work_q[WORK_BITS-2:0], ~borrow};
			end
			ST_MUL: begin
				absm_q <= work_q[SAMPLE_BITS-1:0];
				prod_q <= prod_c;
			end
			ST_DEV: begin
				work_q <= sq_q - prod_q[SQ_BITS-1:0];
				rem_q  <= '0;
			end
			ST_PREP: begin
				rad_q  <= work_q[VAR_BITS-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				if (!done_q) begin
					rem_q  <= borrow ? root_shift : diff;
					root_q <= {root_q[ROOT_BITS-2:0], ~borrow};
					rad_q  <= {rad_q[VAR_BITS-3:0], 2'b00};
				end
			end
			default: begin
			end
		endcase
	end

	assign result.mean         = neg_q ? $signed(-absm_q) : $signed(absm_q);
	assign result.std_dev_q8   = root_q;
	assign result.minimum      = min_q;
	assign result.maximum      = max_q;
	assign result.sample_count = n_q;
	assign result.overflow     = ovf_q;

endmodule

FILE: design/dataset_mean_stddev_minmax.sv
// dataset statistics top level: input handshake, accumulator, engine, output register
// depends on dms_pkg, dms_accum and dms_engine
//
// usage
// samples arrive on the item channel (item_valid, item_ready, item), one word each,
// with item.last set on the final sample of a set. while a set runs and the sequencer
// is idle, a word is taken every cycle and produces nothing on the result channel.
// the word carrying last starts the end-of-set sequence and item_ready drops for
// the whole sequence: a 43-step restoring division of the sum by the count, one
// multiply and one subtract for the deviation sum, a second 43-step division for
// the variance and a 24-step square root, all through one shared subtractor.
// the result word appears on the result channel (result_valid, result_ready,
// result) once the square root has finished and the output register is free;
// sets are taken at one sample a cycle, with no samples taken during the sequence.
// the result sits in an output register; while it waits, the next set's samples
// are still taken, and a following sequence holds its finished word until the
// register frees, keeping item_ready low meanwhile.
// samples beyond the maximum count only raise the overflow flag.
// reset clears the sums, count and overflow flag, the sequencer and the valid flag.
module dataset_mean_stddev_minmax (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  dms_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_ready,
	output dms_pkg::out_t result
);
	import dms_pkg::*;

	acc_t      acc;
	eng_stat_t stat;
	out_t      eng_result;
	out_t      result_q;
	logic      result_valid_q;
	logic      accept, start, taken;

	assign item_ready = !stat.busy;
	assign accept     = item_valid && item_ready;
	assign start      = accept && item.last;
	assign taken      = stat.done && (!result_valid_q || result_ready);

	dms_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (item.sample),
		.clear  (stat.acc_clear),
		.acc    (acc)
	);

	dms_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.taken  (taken),
		.acc    (acc),
		.stat   (stat),
		.result (eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (taken) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (taken) begin
			result_q <= eng_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
